// ===== sv/bitmap_page_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// Bitmap page allocator assertion macros
// Concurrent assertion wrappers on clk_i, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_ASSERT_SVH

// Checked only while out of reset
`define BPA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included
`define BPA_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Request/response types, status codes and free map word constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpa_pkg;

  // Free map word geometry: 64 pages per memory word
  localparam int WORD_W  = 64;
  localparam int IDX_W   = 6;

  // Field widths
  localparam int PAGE_W  = 12;
  localparam int CNT_W   = 13;
  localparam int RUN_W   = CNT_W + 1;

  // Highest start page a response can carry
  localparam int START_LIMIT = 4095;

  // First allocatable page at reset
  localparam logic [PAGE_W-1:0] FIRST_PAGE_RST = 12'd256;

  // Request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_RANGE   = 2'd2
  } status_e;

  typedef struct packed {
    logic              req_type;
    logic [PAGE_W-1:0] page_number;
    logic [CNT_W-1:0]  count;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PAGE_W-1:0] start_page;
  } resp_t;

  // Word scan result
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
    logic [RUN_W-1:0] run;
  } scan_res_t;

endpackage

// ===== sv/bpa_map_ram.sv =====
// ----------------------------------------------------------------------------
// Free map memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpa_map_ram
  import bpa_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== sv/bpa_word_scan.sv =====
// ----------------------------------------------------------------------------
// Free map word scanner
// Finds the lowest page of a 64-page word at which the free run reaches the
// requested length, carrying the run in from lower words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpa_word_scan
  import bpa_pkg::*;
(
  input  logic [WORD_W-1:0] word_i,
  input  logic [IDX_W-1:0]  lo_i,
  input  logic [RUN_W-1:0]  run_i,
  input  logic [CNT_W-1:0]  cnt_i,
  output scan_res_t         res_o
);

  localparam logic [WORD_W-1:0] ONES = '1;

  logic [WORD_W-1:0] bits;
  // len[k][j] = min(ones ending at bit j, 2**k)
  logic [IDX_W:0]    len [IDX_W+1][WORD_W];

  // Pages below the scan start count as taken
  assign bits = word_i & (ONES << lo_i);

  // Run length per bit by doubling, six levels
  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      len[0][j] = {{IDX_W{1'b0}}, bits[j]};
    end
    for (int k = 0; k < IDX_W; k++) begin
      for (int j = 0; j < WORD_W; j++) begin
        if (len[k][j] < (IDX_W+1)'(1 << k)) begin
          len[k+1][j] = len[k][j];
        end else if (j >= (1 << k)) begin
          len[k+1][j] = (IDX_W+1)'(1 << k) + len[k][j-(1 << k)];
        end else begin
          len[k+1][j] = (IDX_W+1)'(1 << k);
        end
      end
    end
  end

  // Lowest bit where the total run reaches the count
  always_comb begin
    logic           full;
    logic [RUN_W:0] tot;
    res_o = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      full = (len[IDX_W][j] == (IDX_W+1)'(j + 1));
      tot  = full ? ({1'b0, run_i} + (RUN_W+1)'(j + 1))
                  : (RUN_W+1)'(len[IDX_W][j]);
      if (tot >= (RUN_W+1)'(cnt_i)) begin
        res_o.hit = 1'b1;
        res_o.idx = IDX_W'(j);
      end
    end
    // Run carried into the next word
    if (len[IDX_W][WORD_W-1] == (IDX_W+1)'(WORD_W)) begin
      res_o.run = run_i + RUN_W'(WORD_W);
    end else begin
      res_o.run = RUN_W'(len[IDX_W][WORD_W-1]);
    end
  end

endmodule

// ===== sv/bitmap_page_allocator.sv =====
// Allocate scans the free map words from first_page upward, 64 pages per cycle (bounded
//   by the single free map read port), then clears the run's bits word by word; free sets bits.
// Requests are taken one at a time.
// Zero-count and out-of-range requests answer without touching the free map.
// Reset: free map cleared to all-allocated by a sweep over every word, during which
//   no request is taken; first_page resets to 256.
// ----------------------------------------------------------------------------
// Bitmap page allocator
// Contiguous page allocator over a one-bit-per-page free map in memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bitmap_page_allocator_assert.svh"

module bitmap_page_allocator
  import bpa_pkg::*;
#(
  parameter int NUM_PAGES = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [PAGE_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  req_t              in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output resp_t             out_resp_o
);

  localparam int WORDS  = (NUM_PAGES + WORD_W - 1) / WORD_W;
  localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int XW_MIN = $clog2(NUM_PAGES) + 1;
  localparam int XW     = (XW_MIN > 14) ? XW_MIN : 14;
  localparam logic [AW-1:0]     LAST_W = AW'(WORDS - 1);
  localparam logic [XW-1:0]     NP_X   = XW'(NUM_PAGES);
  localparam logic [WORD_W-1:0] ONES   = '1;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_SCAN, S_HIT, S_UPD_RD, S_UPD_WR, S_RESP
  } state_e;

  state_e            state_q, state_d;
  logic [PAGE_W-1:0] first_page_q, first_page_d;
  req_t              req_q, req_d;
  logic [RUN_W-1:0]  run_q, run_d;
  logic              first_q, first_d;
  logic [AW-1:0]     cur_w_q, cur_w_d;
  logic [XW-1:0]     hit_page_q, hit_page_d;
  logic [XW-1:0]     ustart_q, ustart_d;
  logic [XW-1:0]     uend_q, uend_d;
  logic [AW-1:0]     upd_w_q, upd_w_d;
  logic              upd_set_q, upd_set_d;
  resp_t             resp_q, resp_d;
  logic              out_valid_q, out_valid_d;
  resp_t             out_resp_q, out_resp_d;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  scan_res_t         scan;
  logic [IDX_W-1:0]  scan_lo;
  logic [AW-1:0]     start_w, u_first_w, u_last_w;
  logic [IDX_W-1:0]  mask_lo, mask_hi;
  logic [WORD_W-1:0] upd_mask;
  logic [XW-1:0]     fsum, fend, hstart;

  // Free map storage
  bpa_map_ram #(
    .DEPTH (WORDS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Word scanner on the read data
  assign scan_lo = first_q ? first_page_q[IDX_W-1:0] : '0;

  bpa_word_scan u_scan (
    .word_i (ram_rdata),
    .lo_i   (scan_lo),
    .run_i  (run_q),
    .cnt_i  (req_q.count),
    .res_o  (scan)
  );

  // Address and mask helpers
  assign start_w   = AW'(first_page_q >> IDX_W);
  assign u_first_w = AW'(ustart_q >> IDX_W);
  assign u_last_w  = AW'(uend_q >> IDX_W);
  assign mask_lo   = (upd_w_q == u_first_w) ? ustart_q[IDX_W-1:0] : '0;
  assign mask_hi   = (upd_w_q == u_last_w) ? uend_q[IDX_W-1:0] : '1;
  assign upd_mask  = (ONES << mask_lo) & (ONES >> (IDX_W'(WORD_W - 1) - mask_hi));

  // Free run end, clipped to the last page
  assign fsum   = XW'(in_req_i.page_number) + XW'(in_req_i.count);
  assign fend   = (fsum > NP_X) ? (NP_X - XW'(1)) : (fsum - XW'(1));
  assign hstart = hit_page_q + XW'(1) - XW'(req_q.count);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_resp_o  = out_resp_q;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    first_page_d = first_page_q;
    req_d        = req_q;
    run_d        = run_q;
    first_d      = first_q;
    cur_w_d      = cur_w_q;
    hit_page_d   = hit_page_q;
    ustart_d     = ustart_q;
    uend_d       = uend_q;
    upd_w_d      = upd_w_q;
    upd_set_d    = upd_set_q;
    resp_d       = resp_q;
    out_valid_d  = out_valid_q;
    out_resp_d   = out_resp_q;
    ram_we       = 1'b0;
    ram_waddr    = upd_w_q;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = upd_w_q;

    if (cfg_we_i) begin
      first_page_d = cfg_wdata_i;
    end

    // Output slot drains independently
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      // Post-reset sweep: all pages allocated
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = upd_w_q;
        ram_wdata = '0;
        upd_w_d   = upd_w_q + AW'(1);
        if (upd_w_q == LAST_W) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          req_d             = in_req_i;
          resp_d.status     = ST_OK;
          resp_d.start_page = '0;
          state_d           = S_RESP;
          if (in_req_i.req_type == REQ_FREE) begin
            if (XW'(in_req_i.page_number) >= NP_X) begin
              resp_d.status = ST_RANGE;
            end else if (in_req_i.count != '0) begin
              ustart_d  = XW'(in_req_i.page_number);
              uend_d    = fend;
              upd_w_d   = AW'(in_req_i.page_number >> IDX_W);
              upd_set_d = 1'b1;
              state_d   = S_UPD_RD;
            end
          end else if (in_req_i.count == '0) begin
            resp_d.start_page = first_page_q;
          end else if (XW'(first_page_q) >= NP_X) begin
            resp_d.status = ST_NOSPACE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = start_w;
            cur_w_d   = start_w;
            run_d     = '0;
            first_d   = 1'b1;
            state_d   = S_SCAN;
          end
        end
      end

      // One word per cycle, next read issued alongside
      S_SCAN: begin
        if (scan.hit) begin
          hit_page_d = (XW'(cur_w_q) << IDX_W) | XW'(scan.idx);
          state_d    = S_HIT;
        end else if (cur_w_q == LAST_W) begin
          resp_d.status = ST_NOSPACE;
          state_d       = S_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = cur_w_q + AW'(1);
          cur_w_d   = cur_w_q + AW'(1);
          run_d     = scan.run;
          first_d   = 1'b0;
        end
      end

      // Run found: check start limit, then mark it taken
      S_HIT: begin
        if (hstart > XW'(START_LIMIT)) begin
          resp_d.status = ST_NOSPACE;
          state_d       = S_RESP;
        end else begin
          resp_d.start_page = PAGE_W'(hstart);
          ustart_d          = hstart;
          uend_d            = hit_page_q;
          upd_w_d           = AW'(hstart >> IDX_W);
          upd_set_d         = 1'b0;
          state_d           = S_UPD_RD;
        end
      end

      S_UPD_RD: begin
        ram_re    = 1'b1;
        ram_raddr = upd_w_q;
        state_d   = S_UPD_WR;
      end

      // Read-modify-write of one word
      S_UPD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = upd_w_q;
        ram_wdata = upd_set_q ? (ram_rdata | upd_mask) : (ram_rdata & ~upd_mask);
        if (upd_w_q == u_last_w) begin
          state_d = S_RESP;
        end else begin
          upd_w_d = upd_w_q + AW'(1);
          state_d = S_UPD_RD;
        end
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_resp_d  = resp_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      first_page_q <= FIRST_PAGE_RST;
      req_q        <= '0;
      run_q        <= '0;
      first_q      <= 1'b0;
      cur_w_q      <= '0;
      hit_page_q   <= '0;
      ustart_q     <= '0;
      uend_q       <= '0;
      upd_w_q      <= '0;
      upd_set_q    <= 1'b0;
      resp_q       <= '0;
      out_valid_q  <= 1'b0;
      out_resp_q   <= '0;
    end else begin
      state_q      <= state_d;
      first_page_q <= first_page_d;
      req_q        <= req_d;
      run_q        <= run_d;
      first_q      <= first_d;
      cur_w_q      <= cur_w_d;
      hit_page_q   <= hit_page_d;
      ustart_q     <= ustart_d;
      uend_q       <= uend_d;
      upd_w_q      <= upd_w_d;
      upd_set_q    <= upd_set_d;
      resp_q       <= resp_d;
      out_valid_q  <= out_valid_d;
      out_resp_q   <= out_resp_d;
    end
  end

  // Checks
  `BPA_ASSERT_RST(a_reset_state,
    (!rst_ni) |=> (state_q == S_CLR && !out_valid_q),
    "reset did not restart the clear sweep")
  `BPA_ASSERT(a_mark_only_free,
    (state_q == S_UPD_WR && !upd_set_q) |-> ((ram_rdata & upd_mask) == upd_mask),
    "allocation marks a page that is not free")
  `BPA_ASSERT(a_scan_no_write,
    (state_q == S_SCAN || state_q == S_HIT) |-> !ram_we,
    "free map written during a scan")
  `BPA_ASSERT(a_nospace_zero,
    (state_q == S_RESP && resp_q.status == 2'(ST_NOSPACE)) |-> (resp_q.start_page == '0),
    "no-space response carries a start page")
  `BPA_ASSERT(a_alloc_above_first,
    (state_q == S_HIT && hstart <= XW'(START_LIMIT)) |-> (hstart >= XW'(first_page_q)),
    "allocated run starts below first page")

endmodule
